>>> rtl/core/bres_pkg.sv
`timescale 1ns / 1ps

package bres_pkg;

    // Default coordinate width (two's complement).
    localparam int COORD_BITS_DEFAULT = 13;

    // Frame size registers.
    localparam int DIM_BITS        = 12;
    localparam int DIM_RESET       = 700;
    localparam int MAX_FRAME_DIM   = 2048;
    localparam int DIM_REG_MAX     = (1 << DIM_BITS) - 1;
    // Saturation limit as it can be seen through a DIM_BITS register.
    localparam logic [DIM_BITS-1:0] DIM_SAT =
        DIM_BITS'((MAX_FRAME_DIM > DIM_REG_MAX) ? DIM_REG_MAX : MAX_FRAME_DIM);

    localparam int ADDR_BITS = 22;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Input beat kinds (carried on s_tuser).
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

endpackage

>>> rtl/core/bresenham_line_pixel_generator_top.sv
`timescale 1ns / 1ps

// Bresenham line engine. A start beat (s_tuser = 0) loads two endpoints and
// returns the first pixel of the line; each step beat (s_tuser = 1) returns
// the next pixel, with m_tlast marking the final one. A step with no line in
// progress returns a beat with m_tuser = 0 and all data zero. Every pixel
// carries an inside-frame flag and the bottom-up row address
// (height-1-y)*width+x, zero when the pixel is off frame. One beat is taken
// per clock unless m_tready back-pressure fills both stages. A result passes
// through two register stages, stage 1 and the output register, before it is
// offered on m_tvalid; the error-term / position update is combinational. The
// frame size registers may be written only while no line beats are in flight.
module bresenham_line_pixel_generator_top #(
    parameter int COORD_BITS = bres_pkg::COORD_BITS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,

    // Configuration write port
    input  logic                              cfg_we,
    input  logic [bres_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [bres_pkg::DIM_BITS-1:0]     cfg_data,

    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // start_x, start_y, end_x, end_y (COORD_BITS each), zero pad
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]   s_tdata,
    // op
    input  logic                                s_tuser,

    // Output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_x, pixel_y, inside_frame, frame_address, zero pad
    output logic [((2*COORD_BITS+1+bres_pkg::ADDR_BITS+7)/8)*8-1:0] m_tdata,
    // pixel_valid
    output logic                                m_tuser,
    // last_pixel
    output logic                                m_tlast
);

    localparam int C      = COORD_BITS;
    localparam int E      = COORD_BITS + 4;                       // error term width
    localparam int DB     = bres_pkg::DIM_BITS;
    localparam int AB     = bres_pkg::ADDR_BITS;
    localparam int WIDE   = ((C > DB) ? C : DB) + 1;              // frame compare width
    localparam int OUT_W  = ((2*C+1+AB+7)/8)*8;
    localparam int PAD_W  = OUT_W - (2*C+1+AB);

    // ------------------------------------------------------------------
    // Frame size registers
    // ------------------------------------------------------------------
    logic [DB-1:0] width_reg;
    logic [DB-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DB'(bres_pkg::DIM_RESET);
            height_reg <= DB'(bres_pkg::DIM_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bres_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                bres_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: stage 1 holds the new position, stage 2 is the output
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic m_valid_reg;
    logic out_move;
    logic s1_move;
    logic in_fire;

    assign out_move = !m_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_move;
    assign s_tready = !s1_valid_reg || out_move;
    assign in_fire  = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Line state and its combinational update
    // ------------------------------------------------------------------
    logic         line_active_reg, line_active_next;
    logic [C-1:0] cur_x_reg, cur_x_next;
    logic [C-1:0] cur_y_reg, cur_y_next;
    logic [C-1:0] major_end_reg, major_end_next;
    logic [C-1:0] abs_dx_reg, abs_dx_next;
    logic [C-1:0] abs_dy_reg, abs_dy_next;
    logic [E-1:0] err_reg, err_next;
    logic         y_major_reg, y_major_next;
    logic         step_up_reg, step_up_next;

    logic         s1_pix_reg, s1_pix_next;
    logic [C-1:0] s1_x_reg, s1_x_next;
    logic [C-1:0] s1_y_reg, s1_y_next;
    logic         s1_last_reg, s1_last_next;

    logic [C-1:0] sx, sy, ex, ey;
    logic [C:0]   dx, dy, adx_full, ady_full;
    logic         dx_neg, dy_neg, dx_zero, dy_zero;
    logic [C-1:0] st_adx, st_ady;
    logic         st_ymaj;
    logic [E-1:0] st_2dx, st_2dy, d2x, d2y;
    logic [C-1:0] minor_step;
    logic [C-1:0] nx, ny, nend;
    logic [E-1:0] nerr;
    logic         nlast;

    assign sx = s_tdata[0*C +: C];
    assign sy = s_tdata[1*C +: C];
    assign ex = s_tdata[2*C +: C];
    assign ey = s_tdata[3*C +: C];

    assign dx = {ex[C-1], ex} - {sx[C-1], sx};
    assign dy = {ey[C-1], ey} - {sy[C-1], sy};
    assign dx_neg  = dx[C];
    assign dy_neg  = dy[C];
    assign dx_zero = (dx == '0);
    assign dy_zero = (dy == '0);
    assign adx_full = dx_neg ? (~dx + 1'b1) : dx;
    assign ady_full = dy_neg ? (~dy + 1'b1) : dy;
    assign st_adx  = adx_full[C-1:0];
    assign st_ady  = ady_full[C-1:0];
    assign st_ymaj = (st_ady > st_adx);
    assign st_2dx  = {{(E-C-1){1'b0}}, st_adx, 1'b0};
    assign st_2dy  = {{(E-C-1){1'b0}}, st_ady, 1'b0};

    // Doubled deltas of the stored line
    assign d2x = {{(E-C-1){1'b0}}, abs_dx_reg, 1'b0};
    assign d2y = {{(E-C-1){1'b0}}, abs_dy_reg, 1'b0};
    assign minor_step = step_up_reg ? C'(1) : '1;

    always_comb
    begin
        nx    = cur_x_reg;
        ny    = cur_y_reg;
        nend  = major_end_reg;
        nerr  = err_reg;
        nlast = 1'b0;

        if (s_tuser == bres_pkg::OP_STEP)
        begin
            if (!y_major_reg)
            begin
                nx = cur_x_reg + C'(1);
                if (err_reg[E-1])
                begin
                    nerr = err_reg + d2y;
                end
                else
                begin
                    ny   = cur_y_reg + minor_step;
                    nerr = err_reg + d2y - d2x;
                end
                nlast = ($signed(nx) >= $signed(major_end_reg));
            end
            else
            begin
                ny = cur_y_reg + C'(1);
                // y-major holds the minor axis on zero as well
                if (err_reg[E-1] || (err_reg == '0))
                begin
                    nerr = err_reg + d2x;
                end
                else
                begin
                    nx   = cur_x_reg + minor_step;
                    nerr = err_reg + d2x - d2y;
                end
                nlast = ($signed(ny) >= $signed(major_end_reg));
            end
        end
        else
        begin
            // Start at the endpoint with the lower major coordinate
            if (!st_ymaj)
            begin
                nerr = st_2dy - {{(E-C){1'b0}}, st_adx};
                if (dx_neg)
                begin
                    nx = ex; ny = ey; nend = sx;
                end
                else
                begin
                    nx = sx; ny = sy; nend = ex;
                end
                nlast = ($signed(nx) >= $signed(nend));
            end
            else
            begin
                nerr = st_2dx - {{(E-C){1'b0}}, st_ady};
                if (dy_neg)
                begin
                    nx = ex; ny = ey; nend = sy;
                end
                else
                begin
                    nx = sx; ny = sy; nend = ey;
                end
                nlast = ($signed(ny) >= $signed(nend));
            end
        end
    end

    always_comb
    begin
        line_active_next = line_active_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        major_end_next   = major_end_reg;
        abs_dx_next      = abs_dx_reg;
        abs_dy_next      = abs_dy_reg;
        err_next         = err_reg;
        y_major_next     = y_major_reg;
        step_up_next     = step_up_reg;
        s1_pix_next      = 1'b0;
        s1_x_next        = '0;
        s1_y_next        = '0;
        s1_last_next     = 1'b0;

        if (s_tuser == bres_pkg::OP_STEP)
        begin
            if (line_active_reg)
            begin
                cur_x_next       = nx;
                cur_y_next       = ny;
                err_next         = nerr;
                line_active_next = !nlast;
                s1_pix_next      = 1'b1;
                s1_x_next        = nx;
                s1_y_next        = ny;
                s1_last_next     = nlast;
            end
        end
        else
        begin
            cur_x_next       = nx;
            cur_y_next       = ny;
            major_end_next   = nend;
            abs_dx_next      = st_adx;
            abs_dy_next      = st_ady;
            err_next         = nerr;
            y_major_next     = st_ymaj;
            step_up_next     = (dx_neg && dy_neg) ||
                               (!dx_neg && !dx_zero && !dy_neg && !dy_zero);
            line_active_next = !nlast;
            s1_pix_next      = 1'b1;
            s1_x_next        = nx;
            s1_y_next        = ny;
            s1_last_next     = nlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            major_end_reg   <= '0;
            abs_dx_reg      <= '0;
            abs_dy_reg      <= '0;
            err_reg         <= '0;
            y_major_reg     <= 1'b0;
            step_up_reg     <= 1'b0;
        end
        else if (in_fire)
        begin
            line_active_reg <= line_active_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            major_end_reg   <= major_end_next;
            abs_dx_reg      <= abs_dx_next;
            abs_dy_reg      <= abs_dy_next;
            err_reg         <= err_next;
            y_major_reg     <= y_major_next;
            step_up_reg     <= step_up_next;
        end
    end

    // Stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg  <= s1_pix_next;
            s1_x_reg    <= s1_x_next;
            s1_y_reg    <= s1_y_next;
            s1_last_reg <= s1_last_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: frame test and row-flipped address
    // ------------------------------------------------------------------
    logic [DB-1:0]    w_eff, h_eff;
    logic [WIDE-1:0]  x_w, y_w;
    logic             in_frame;
    logic [DB-1:0]    row;
    logic [2*DB-1:0]  prod;
    logic [2*DB-1:0]  addr_full;
    logic [AB-1:0]    addr;

    assign w_eff = (width_reg  > bres_pkg::DIM_SAT) ? bres_pkg::DIM_SAT : width_reg;
    assign h_eff = (height_reg > bres_pkg::DIM_SAT) ? bres_pkg::DIM_SAT : height_reg;

    assign x_w = {{(WIDE-C){s1_x_reg[C-1]}}, s1_x_reg};
    assign y_w = {{(WIDE-C){s1_y_reg[C-1]}}, s1_y_reg};

    assign in_frame = s1_pix_reg &&
                      !x_w[WIDE-1] && (x_w < {{(WIDE-DB){1'b0}}, w_eff}) &&
                      !y_w[WIDE-1] && (y_w < {{(WIDE-DB){1'b0}}, h_eff});

    assign row       = h_eff - DB'(1) - y_w[DB-1:0];
    assign prod      = row * w_eff;
    assign addr_full = prod + {{DB{1'b0}}, x_w[DB-1:0]};
    assign addr      = in_frame ? addr_full[AB-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_move)
        begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    logic [C-1:0]  m_x_reg, m_y_reg;
    logic          m_inside_reg;
    logic [AB-1:0] m_addr_reg;
    logic          m_pix_reg;
    logic          m_last_reg;

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            m_x_reg      <= s1_x_reg;
            m_y_reg      <= s1_y_reg;
            m_inside_reg <= in_frame;
            m_addr_reg   <= addr;
            m_pix_reg    <= s1_pix_reg;
            m_last_reg   <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_pix_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_addr_reg, m_inside_reg, m_y_reg, m_x_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A step with no line yields an all-zero beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0) && !m_tlast)
        else $error("idle step beat carries nonzero payload");

    // Off-frame pixels carry a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_inside_reg) |-> (m_addr_reg == '0))
        else $error("address set for off-frame pixel");

    // A start always produces a pixel in stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (s_tuser == bres_pkg::OP_START)) |=> (s1_valid_reg && s1_pix_reg))
        else $error("start beat produced no pixel");

    // A pixel flagged last leaves no line active
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s1_pix_next && s1_last_next) |=> !line_active_reg)
        else $error("line still active after last pixel");

    // Input is never blocked while the output register is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with empty output stage");

endmodule

>>> tb/sv/bresenham_line_pixel_generator_top_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the line engine. Beats go in through a backlog
// queue. Every accepted input beat runs through a local line tracer that
// pushes the pixel it expects, and output beats are checked in order against
// that store.
module bresenham_line_pixel_generator_top_tb;

    localparam int CW       = bres_pkg::COORD_BITS_DEFAULT;
    localparam int EW       = CW + 4;
    localparam int DW       = bres_pkg::DIM_BITS;
    localparam int IN_W     = ((4 * CW + 7) / 8) * 8;
    localparam int OUT_W    = ((2 * CW + 1 + bres_pkg::ADDR_BITS + 7) / 8) * 8;
    localparam int AW       = bres_pkg::ADDR_BITS;
    localparam int MAX_DIM  = bres_pkg::MAX_FRAME_DIM;

    // Output beat layout: pixel_x, pixel_y, inside_frame, frame_address.
    localparam int OFS_Y    = CW;
    localparam int OFS_IN   = 2 * CW;
    localparam int OFS_ADDR = 2 * CW + 1;

    localparam int LONG_HOLD    = 400;   // receiver back-pressure stretch
    localparam int STALL_LIMIT  = 4000;  // cycles with no beat moving
    localparam int PHASE_ITEMS  = 185;
    localparam int NUM_PHASES   = 7;

    typedef struct {
        logic                 valid;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 in_frame;
        logic [AW-1:0]        addr;
        logic                 last;
    } pixel_t;

    typedef struct {
        logic                 op;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        bit                   typed;   // expected pixel given in the row itself
        pixel_t               want;
    } line_beat_t;

    // DUT ports; the inputs are driven from time zero
    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [bres_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [DW-1:0]                cfg_data = '0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [IN_W-1:0]              s_tdata = '0;
    logic                         s_tuser = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [OUT_W-1:0]             m_tdata;
    logic                         m_tuser;
    logic                         m_tlast;

    // Tracer copy of the block state and the frame registers
    logic [DW-1:0]        frame_w = DW'(bres_pkg::DIM_RESET);
    logic [DW-1:0]        frame_h = DW'(bres_pkg::DIM_RESET);
    bit                   line_on = 1'b0;
    logic signed [CW-1:0] pos_x = '0;
    logic signed [CW-1:0] pos_y = '0;
    logic signed [CW-1:0] major_stop = '0;
    logic [CW-1:0]        span_x = '0;
    logic [CW-1:0]        span_y = '0;
    logic signed [EW-1:0] err_acc = '0;
    bit                   steep = 1'b0;
    bit                   minor_up = 1'b0;

    line_beat_t beat_backlog[$];     // beats waiting to be offered
    pixel_t     pending_pixels[$];   // expected output beats, oldest first
    line_beat_t offered_beat;

    int  mismatches = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  calm_left = 0;
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;
    int  idle_cycles = 0;

    bresenham_line_pixel_generator_top #(
        .COORD_BITS(CW)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // Frame registers saturate at the largest supported dimension.
    function automatic int frame_dim(input logic [DW-1:0] r);
        return (int'(r) > MAX_DIM) ? MAX_DIM : int'(r);
    endfunction

    function automatic pixel_t mk_pix(input int v, input int x, input int y,
                                      input int ins, input int addr, input int last);
        pixel_t p;
        p.valid    = (v != 0);
        p.x        = CW'(x);
        p.y        = CW'(y);
        p.in_frame = (ins != 0);
        p.addr     = AW'(addr);
        p.last     = (last != 0);
        return p;
    endfunction

    function automatic line_beat_t mk_beat(input logic op, input int sx, input int sy,
                                           input int ex, input int ey);
        line_beat_t b;
        b.op    = op;
        b.sx    = CW'(sx);
        b.sy    = CW'(sy);
        b.ex    = CW'(ex);
        b.ey    = CW'(ey);
        b.typed = 1'b0;
        b.want  = mk_pix(0, 0, 0, 0, 0, 0);
        return b;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Coordinate biased toward the frame edges; one in ten is any 13-bit value.
    function automatic logic signed [CW-1:0] pick_coord(input int dim);
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return CW'($urandom);
            1, 2:    return CW'(int'($urandom_range(0, 20)) - 10);
            3, 4:    return CW'(dim + int'($urandom_range(0, 20)) - 10);
            default: return CW'($urandom_range(0, (dim > 0) ? dim - 1 : 0));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Line tracer: mirrors the block state for one accepted beat
    // ------------------------------------------------------------------

    function automatic pixel_t pixel_at(input bit last);
        int w;
        int h;
        int xi;
        int yi;
        pixel_t p;
        w  = frame_dim(frame_w);
        h  = frame_dim(frame_h);
        xi = pos_x;
        yi = pos_y;
        p.valid    = 1'b1;
        p.x        = pos_x;
        p.y        = pos_y;
        p.in_frame = (xi >= 0) && (xi < w) && (yi >= 0) && (yi < h);
        // bottom-up rows: row 0 of memory holds the top scanline
        p.addr     = p.in_frame ? AW'((h - 1 - yi) * w + xi) : '0;
        p.last     = last;
        return p;
    endfunction

    task automatic trace_beat(input line_beat_t b);
        int x1;
        int y1;
        int x2;
        int y2;
        int dx;
        int dy;
        int err;
        int stride;
        bit done;
        pixel_t p;
        if (b.op == bres_pkg::OP_START)
        begin
            x1 = b.sx;
            y1 = b.sy;
            x2 = b.ex;
            y2 = b.ey;
            dx = x2 - x1;
            dy = y2 - y1;
            span_x   = CW'((dx < 0) ? -dx : dx);
            span_y   = CW'((dy < 0) ? -dy : dy);
            minor_up = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
            steep    = span_y > span_x;
            // always walk from the endpoint with the lower major coordinate
            if (!steep)
            begin
                err = 2 * int'(span_y) - int'(span_x);
                if (dx >= 0)
                begin
                    pos_x = b.sx; pos_y = b.sy; major_stop = b.ex;
                end
                else
                begin
                    pos_x = b.ex; pos_y = b.ey; major_stop = b.sx;
                end
                done = pos_x >= major_stop;
            end
            else
            begin
                err = 2 * int'(span_x) - int'(span_y);
                if (dy >= 0)
                begin
                    pos_x = b.sx; pos_y = b.sy; major_stop = b.ey;
                end
                else
                begin
                    pos_x = b.ex; pos_y = b.ey; major_stop = b.sy;
                end
                done = pos_y >= major_stop;
            end
            err_acc = EW'(err);
            line_on = !done;
            p = pixel_at(done);
        end
        else if (!line_on)
        begin
            p = mk_pix(0, 0, 0, 0, 0, 0);
        end
        else
        begin
            stride = minor_up ? 1 : -1;
            err    = err_acc;
            // error tests differ by axis: strict on x-major, inclusive on y-major
            if (!steep)
            begin
                pos_x = CW'(pos_x + 1);
                if (err < 0)
                    err += 2 * int'(span_y);
                else
                begin
                    pos_y = CW'(pos_y + stride);
                    err += 2 * (int'(span_y) - int'(span_x));
                end
                done = pos_x >= major_stop;
            end
            else
            begin
                pos_y = CW'(pos_y + 1);
                if (err <= 0)
                    err += 2 * int'(span_x);
                else
                begin
                    pos_x = CW'(pos_x + stride);
                    err += 2 * (int'(span_x) - int'(span_y));
                end
                done = pos_y >= major_stop;
            end
            err_acc = EW'(err);
            line_on = !done;
            p = pixel_at(done);
        end
        pending_pixels.push_back(b.typed ? b.want : p);
    endtask

    // ------------------------------------------------------------------
    // Input side: offers backlog beats with random gaps, traces each beat
    // at the edge where it is taken.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                trace_beat(offered_beat);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (beat_backlog.size() > 0)
                begin
                    offered_beat = beat_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= offered_beat.op;
                    s_tdata  <= {{(IN_W - 4 * CW){1'b0}}, offered_beat.ey,
                                 offered_beat.ex, offered_beat.sy, offered_beat.sx};
                    send_gap = calm ? 0 : gap_len();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random back-pressure plus one long hold on request;
    // each taken beat is compared with the oldest expected pixel.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.valid    = m_tuser;
                got.x        = m_tdata[CW-1:0];
                got.y        = m_tdata[OFS_Y +: CW];
                got.in_frame = m_tdata[OFS_IN];
                got.addr     = m_tdata[OFS_ADDR +: AW];
                got.last     = m_tlast;
                if (pending_pixels.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: pixel beat with nothing pending: v=%0b x=%0d y=%0d",
                                 $realtime, got.valid, got.x, got.y);
                    mismatches++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (got.valid !== want.valid || got.x !== want.x || got.y !== want.y ||
                        got.in_frame !== want.in_frame || got.addr !== want.addr ||
                        got.last !== want.last)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: pixel beat mismatch",
                                      " exp v=%0b x=%0d y=%0d in=%0b a=%0d l=%0b",
                                      " got v=%0b x=%0d y=%0d in=%0b a=%0d l=%0b"},
                                     $realtime, want.valid, want.x, want.y,
                                     want.in_frame, want.addr, want.last,
                                     got.valid, got.x, got.y,
                                     got.in_frame, got.addr, got.last);
                        mismatches++;
                    end
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm)
                    stall_left = gap_len();
            end
        end
    end

    // Occasional stretches with no idling on either side.
    always @(negedge clk)
    begin
        if (calm_left > 0)
            calm_left--;
        else if ($urandom_range(0, 299) == 0)
            calm_left = $urandom_range(40, 160);
        calm = calm_left > 0;
    end

    // Watchdog: ends the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    // Wait until every beat has been sent and answered, then let the
    // pipeline settle before touching the frame registers.
    task automatic wait_for_idle();
        do
            @(negedge clk);
        while (beat_backlog.size() != 0 || s_tvalid || pending_pixels.size() != 0);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_frame_reg(input logic [bres_pkg::CFG_IDX_BITS-1:0] idx,
                                   input int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= DW'(val);
        if (idx == bres_pkg::REG_FRAME_WIDTH)
            frame_w = DW'(val);
        else
            frame_h = DW'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One run: mostly a start and the steps that walk its line, sometimes cut
    // short or overrun; a few lone steps as noise.
    task automatic queue_line_run(output int n);
        line_beat_t b;
        int w;
        int h;
        int dx;
        int dy;
        int len;
        int steps;
        int d;
        w = frame_dim(frame_w);
        h = frame_dim(frame_h);
        if ($urandom_range(0, 99) < 5)
        begin
            beat_backlog.push_back(mk_beat(bres_pkg::OP_STEP, $urandom, $urandom,
                                           $urandom, $urandom));
            n = 1;
        end
        else
        begin
            b = mk_beat(bres_pkg::OP_START, pick_coord(w), pick_coord(h), 0, 0);
            if ($urandom_range(0, 4) == 0)
            begin
                b.ex = pick_coord(w);
                b.ey = pick_coord(h);
            end
            else
            begin
                d = $urandom_range(0, 24);
                b.ex = CW'(b.sx + d - 12);
                d = $urandom_range(0, 24);
                b.ey = CW'(b.sy + d - 12);
            end
            beat_backlog.push_back(b);
            dx  = int'(b.ex) - int'(b.sx);
            dy  = int'(b.ey) - int'(b.sy);
            dx  = (dx < 0) ? -dx : dx;
            dy  = (dy < 0) ? -dy : dy;
            len = (dx > dy) ? dx : dy;
            steps = (len > 40) ? $urandom_range(0, 40) : len;
            if ($urandom_range(0, 99) < 15)
                steps = $urandom_range(0, steps);
            if ($urandom_range(0, 99) < 20)
                steps += $urandom_range(1, 2);
            // step beats carry random filler in the coordinate fields
            repeat (steps)
                beat_backlog.push_back(mk_beat(bres_pkg::OP_STEP, $urandom, $urandom,
                                               $urandom, $urandom));
            n = steps + 1;
        end
    endtask

    initial
    begin
        line_beat_t directed_rows[$];
        line_beat_t b;
        int queued;
        int n;
        int new_w;
        int new_h;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table, reset frame of 700 x 700. Rows with typed pixels
        // are checked against those values, the rest against the tracer.
        b = mk_beat(bres_pkg::OP_STEP, 0, 0, 0, 0);           // step with no line
        b.typed = 1'b1; b.want = mk_pix(0, 0, 0, 0, 0, 0);
        directed_rows.push_back(b);
        b = mk_beat(bres_pkg::OP_START, 5, 5, 5, 5);          // single point line
        b.typed = 1'b1; b.want = mk_pix(1, 5, 5, 1, 485805, 1);
        directed_rows.push_back(b);
        b = mk_beat(bres_pkg::OP_STEP, -1, -1, -1, -1);       // line already closed
        b.typed = 1'b1; b.want = mk_pix(0, 0, 0, 0, 0, 0);
        directed_rows.push_back(b);
        b = mk_beat(bres_pkg::OP_START, -4096, -4096, 4095, 4095);  // full diagonal
        b.typed = 1'b1; b.want = mk_pix(1, -4096, -4096, 0, 0, 0);
        directed_rows.push_back(b);
        directed_rows.push_back(mk_beat(bres_pkg::OP_STEP, 0, 0, 0, 0));
        // start over an active line, reversed extreme endpoints
        directed_rows.push_back(mk_beat(bres_pkg::OP_START, 4095, 4095, -4096, -4096));
        directed_rows.push_back(mk_beat(bres_pkg::OP_STEP, 0, 0, 0, 0));
        // shallow line rising, walked to its end and one step past
        directed_rows.push_back(mk_beat(bres_pkg::OP_START, 0, 0, 3, 1));
        repeat (4) directed_rows.push_back(mk_beat(bres_pkg::OP_STEP, 0, 0, 0, 0));
        // shallow line with opposite signs: minor axis falls
        directed_rows.push_back(mk_beat(bres_pkg::OP_START, 10, 0, 0, 3));
        repeat (2) directed_rows.push_back(mk_beat(bres_pkg::OP_STEP, 0, 0, 0, 0));
        // steep line, replaces the one above mid-walk
        directed_rows.push_back(mk_beat(bres_pkg::OP_START, 0, 0, 1, 4));
        repeat (4) directed_rows.push_back(mk_beat(bres_pkg::OP_STEP, 0, 0, 0, 0));
        b = mk_beat(bres_pkg::OP_START, 699, 699, 699, 699);  // top-right corner
        b.typed = 1'b1; b.want = mk_pix(1, 699, 699, 1, 699, 1);
        directed_rows.push_back(b);
        // vertical line given top-down, zero dx
        directed_rows.push_back(mk_beat(bres_pkg::OP_START, 7, 3, 7, 0));
        directed_rows.push_back(mk_beat(bres_pkg::OP_STEP, 0, 0, 0, 0));
        directed_rows.push_back(mk_beat(bres_pkg::OP_START, 0, 0, 4095, -4096));
        directed_rows.push_back(mk_beat(bres_pkg::OP_STEP, 0, 0, 0, 0));
        foreach (directed_rows[i])
            beat_backlog.push_back(directed_rows[i]);
        wait_for_idle();

        // Random phases, each under its own frame size; the block is drained
        // between phases so register writes never meet a beat in flight.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin new_w = 32;   new_h = 24;   end
                1: begin new_w = 1;    new_h = 1;    end
                2: begin new_w = 2048; new_h = 2048; end
                3: begin new_w = 4095; new_h = 4095; end   // saturates
                4: begin new_w = 0;    new_h = 0;    end   // nothing visible
                5: begin new_w = 4095; new_h = 1;    end
                default:
                begin
                    new_w = $urandom_range(0, 4095);
                    new_h = $urandom_range(0, 4095);
                end
            endcase
            write_frame_reg(bres_pkg::REG_FRAME_WIDTH, new_w);
            write_frame_reg(bres_pkg::REG_FRAME_HEIGHT, new_h);
            @(negedge clk);
            queued = 0;
            while (queued < PHASE_ITEMS)
            begin
                queue_line_run(n);
                queued += n;
            end
            // one long receiver hold while the sender keeps offering beats,
            // so the block backs up and drops s_tready
            if (p == 2)
                hold_req = 1'b1;
            wait_for_idle();
        end

        repeat (10) @(posedge clk);
        mismatches += pending_pixels.size();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> bresenham_line_pixel_generator_top.f
rtl/core/bres_pkg.sv
rtl/core/bresenham_line_pixel_generator_top.sv
tb/sv/bresenham_line_pixel_generator_top_tb.sv
